// ===== rtl/core/phase_barrier_with_tx_count_assert.svh =====
// Assertion macros for the phase barrier block.
// Used by phase_barrier_with_tx_count.sv; expects clk and arst_n in scope.
`ifndef PHASE_BARRIER_WITH_TX_COUNT_ASSERT_SVH
`define PHASE_BARRIER_WITH_TX_COUNT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBTC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ((ante) |-> (cons))) \
		else $error("phase barrier: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PBTC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ((ante) |=> (cons))) \
		else $error("phase barrier: next-cycle check failed");

`endif

// ===== rtl/core/pbtc_pkg.sv =====
// Package for the phase barrier block: count width, operation and error codes.
// Has no dependencies; used by phase_barrier_with_tx_count.
`timescale 1ns / 1ps
`default_nettype none

package pbtc_pkg;

	localparam int COUNT_BITS = 20;

	typedef logic [COUNT_BITS-1:0] count_t;

	typedef enum logic [1:0] {
		ACT_ARRIVE     = 2'd0,
		ACT_CHECK      = 2'd1,
		ACT_INVALIDATE = 2'd2,
		ACT_INIT       = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_UNINIT     = 3'd1,
		ERR_CORRUPT    = 3'd2,
		ERR_INVALID    = 3'd3,
		ERR_UNDERFLOW  = 3'd4,
		ERR_OVERARRIVE = 3'd5
	} err_t;

endpackage

`default_nettype wire

// ===== rtl/core/phase_barrier_with_tx_count.sv =====
// The result is registered: a request passes the input register, then the result register.
// Throughput: one request per cycle unless out_ready stalls; the barrier state is updated as a
// request leaves the input register, so the next request sees it without a bubble.
// Reset: arst_n clears both stage valids and the whole barrier state asynchronously.
// Depends on pbtc_pkg and phase_barrier_with_tx_count_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "phase_barrier_with_tx_count_assert.svh"

module phase_barrier_with_tx_count (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire pbtc_pkg::action_t action,
	input  wire pbtc_pkg::count_t count,
	input  wire pbtc_pkg::count_t tx_bytes,
	input  wire logic             tx_complete,
	input  wire logic             parity,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  fault,
	output pbtc_pkg::err_t        error_code,
	output logic                  completed,
	output logic                  phase_after,
	output logic                  predicate
);
	import pbtc_pkg::*;

	logic    valid_s1;
	action_t action_s1;
	count_t  count_s1;
	count_t  delta_s1;
	logic    complete_s1;
	logic    parity_s1;

	logic    valid_s2;
	logic    fault_s2;
	err_t    err_s2;
	logic    done_s2;
	logic    phase_s2;
	logic    pred_s2;

	logic    init_q;
	count_t  expected_q;
	count_t  pending_arr_q;
	count_t  pending_bytes_q;
	logic    phase_q;
	logic    locked_q;
	logic    corrupt_q;
	logic    invalid_q;

	logic    init_d;
	count_t  expected_d;
	count_t  pending_arr_d;
	count_t  pending_bytes_d;
	logic    phase_d;
	logic    locked_d;
	logic    corrupt_d;
	logic    invalid_d;
	logic    fault_d;
	err_t    err_d;
	logic    done_d;
	logic    nph_d;
	logic    pred_d;

	logic    advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		logic [COUNT_BITS:0] sum;
		logic                stop;
		init_d          = init_q;
		expected_d      = expected_q;
		pending_arr_d   = pending_arr_q;
		pending_bytes_d = pending_bytes_q;
		phase_d         = phase_q;
		locked_d        = locked_q;
		corrupt_d       = corrupt_q;
		invalid_d       = invalid_q;
		fault_d         = 1'b0;
		err_d           = ERR_NONE;
		done_d          = 1'b0;
		nph_d           = 1'b0;
		pred_d          = 1'b0;
		stop            = 1'b0;
		sum             = {1'b0, pending_bytes_q} + {1'b0, delta_s1};
		case (action_s1)
			ACT_ARRIVE: begin
				if (!init_q) begin
					fault_d = 1'b1;
					err_d   = ERR_UNINIT;
				end else if (corrupt_q) begin
					fault_d = 1'b1;
					err_d   = ERR_CORRUPT;
				end else if (invalid_q) begin
					fault_d = 1'b1;
					err_d   = ERR_INVALID;
				end else if (!locked_q) begin
					if (complete_s1) begin
						if (delta_s1 > pending_bytes_q) begin
							pending_bytes_d = '0;
							corrupt_d       = 1'b1;
							err_d           = ERR_UNDERFLOW;
							stop            = 1'b1;
						end else begin
							pending_bytes_d = pending_bytes_q - delta_s1;
						end
					end else begin
						pending_bytes_d = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
					end
					if (!stop) begin
						if (count_s1 > pending_arr_q) begin
							locked_d = 1'b1;
							fault_d  = 1'b1;
							err_d    = ERR_OVERARRIVE;
						end else if (count_s1 == pending_arr_q && pending_bytes_d == '0) begin
							phase_d       = !phase_q;
							pending_arr_d = expected_q;
							done_d        = 1'b1;
							nph_d         = !phase_q;
						end else begin
							pending_arr_d = pending_arr_q - count_s1;
						end
					end
				end
			end
			ACT_CHECK: begin
				if (!init_q) begin
					fault_d = 1'b1;
					err_d   = ERR_UNINIT;
				end else if (corrupt_q) begin
					fault_d = 1'b1;
					err_d   = ERR_CORRUPT;
				end else if (!invalid_q && !locked_q) begin
					pred_d = phase_q != parity_s1;
				end
			end
			ACT_INVALIDATE: begin
				invalid_d = 1'b1;
			end
			ACT_INIT: begin
				init_d          = 1'b1;
				expected_d      = count_s1;
				pending_arr_d   = count_s1;
				pending_bytes_d = '0;
				phase_d         = 1'b0;
				locked_d        = 1'b0;
				corrupt_d       = 1'b0;
				invalid_d       = 1'b0;
			end
			default: begin
				fault_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			valid_s2        <= 1'b0;
			init_q          <= 1'b0;
			expected_q      <= '0;
			pending_arr_q   <= '0;
			pending_bytes_q <= '0;
			phase_q         <= 1'b0;
			locked_q        <= 1'b0;
			corrupt_q       <= 1'b0;
			invalid_q       <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2        <= 1'b1;
				init_q          <= init_d;
				expected_q      <= expected_d;
				pending_arr_q   <= pending_arr_d;
				pending_bytes_q <= pending_bytes_d;
				phase_q         <= phase_d;
				locked_q        <= locked_d;
				corrupt_q       <= corrupt_d;
				invalid_q       <= invalid_d;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1   <= action;
			count_s1    <= count;
			delta_s1    <= tx_bytes;
			complete_s1 <= tx_complete;
			parity_s1   <= parity;
		end
		if (advance) begin
			fault_s2 <= fault_d;
			err_s2   <= err_d;
			done_s2  <= done_d;
			phase_s2 <= nph_d;
			pred_s2  <= pred_d;
		end
	end

	assign out_valid   = valid_s2;
	assign fault       = fault_s2;
	assign error_code  = err_s2;
	assign completed   = done_s2;
	assign phase_after = phase_s2;
	assign predicate   = pred_s2;

	`PBTC_ASSERT_SAME(a_fault_has_code, valid_s2 && fault_s2, err_s2 != ERR_NONE)
	`PBTC_ASSERT_SAME(a_done_clean, valid_s2 && done_s2, !fault_s2 && err_s2 == ERR_NONE)
	`PBTC_ASSERT_SAME(a_marks_need_init, locked_q || corrupt_q || pending_bytes_q != '0, init_q)
	`PBTC_ASSERT_NEXT(a_s1_holds, valid_s1 && !advance, valid_s1)

endmodule

`default_nettype wire
